>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer: screen geometry,
// control character codes, command codes, the address unit request and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int C_COLS     = 80;
    localparam int C_ROWS     = 25;
    localparam int C_TAB_STOP = 8;
    localparam int C_CELLS    = C_COLS * C_ROWS;

    // Widths
    localparam int C_COL_W  = 7;
    localparam int C_ROW_W  = 5;
    localparam int C_IDX_W  = 11;
    localparam int C_ADDR_W = $clog2(C_CELLS);
    localparam int C_SUM_W  = C_ADDR_W + 1;
    localparam int C_TAB_W  = $clog2(C_TAB_STOP);
    localparam int C_CELL_W = 16;
    localparam int C_CMD_W  = 2;

    // Command codes
    localparam logic [C_CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [C_CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [C_CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Address unit operations
    typedef enum logic [1:0] {
        ALU_CELL     = 2'd0,  // row base + column
        ALU_ROW_DOWN = 2'd1,  // row base + one row
        ALU_SRC      = 2'd2   // sweep count + one row
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [C_ADDR_W-1:0]   row_base;
        logic [C_COL_W-1:0]    col;
        logic [C_ADDR_W-1:0]   cnt;
    } t_alu_req;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_WRITE  = 9'b000000010,
        S_NEXT   = 9'b000000100,
        S_SCROLL = 9'b000001000,
        S_FLUSH  = 9'b000010000,
        S_CLEAR  = 9'b000100000,
        S_READ   = 9'b001000000,
        S_RDATA  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

endpackage

>>> hdl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tcw_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_alu
// Shared address adder. Forms cell addresses, the next row base and the
// source address of the scroll copy, one request per cycle.
// ----------------------------------------------------------------------------
module tcw_alu (
    input  tcw_pkg::t_alu_req             i_req,
    output logic [tcw_pkg::C_SUM_W-1:0]   o_sum
);

    logic [tcw_pkg::C_SUM_W-1:0] w_a;
    logic [tcw_pkg::C_SUM_W-1:0] w_b;

    // Select operands for the requested operation
    always_comb begin
        case (i_req.op)
            tcw_pkg::ALU_CELL: begin
                w_a = tcw_pkg::C_SUM_W'(i_req.row_base);
                w_b = tcw_pkg::C_SUM_W'(i_req.col);
            end
            tcw_pkg::ALU_ROW_DOWN: begin
                w_a = tcw_pkg::C_SUM_W'(i_req.row_base);
                w_b = tcw_pkg::C_SUM_W'(tcw_pkg::C_COLS);
            end
            tcw_pkg::ALU_SRC: begin
                w_a = tcw_pkg::C_SUM_W'(i_req.cnt);
                w_b = tcw_pkg::C_SUM_W'(tcw_pkg::C_COLS);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_sum = w_a + w_b;

endmodule

>>> hdl/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine: 80x25 cell store in RAM, cursor, control characters,
// scroll, cell read and screen clear, run by a small sequencer around one
// shared address adder.
// ----------------------------------------------------------------------------
// CR, tab, no-op, blocked backspace, bad read index: straight to the result.
// Backspace, printable write: a cell write, and a line advance when it wraps.
// Newline, wrapping tab: a line advance. Read: a store read, then a data
// step. A line advance off the last row adds a scroll pass over the store;
// clear screen sweeps every cell. One word at a time: the next is taken once
// the result sits in the output register. Reset clears the store, ready low.
module text_console_writer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcw_pkg::C_CMD_W-1:0]    i_cmd,
    input  logic [7:0]                     i_char_code,
    input  logic [3:0]                     i_fg_color,
    input  logic [3:0]                     i_bg_color,
    input  logic [tcw_pkg::C_IDX_W-1:0]    i_cell_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcw_pkg::C_CELL_W-1:0]   o_read_data,
    output logic [tcw_pkg::C_COL_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::C_ROW_W-1:0]    o_cursor_row,
    output logic                           o_did_scroll
);

    localparam int CW = tcw_pkg::C_COL_W;
    localparam int RW = tcw_pkg::C_ROW_W;
    localparam int AW = tcw_pkg::C_ADDR_W;
    localparam int TW = tcw_pkg::C_TAB_W;
    localparam int DW = tcw_pkg::C_CELL_W;

    tcw_pkg::t_state r_state, n_state;
    logic            r_boot, n_boot;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_row_base, n_row_base;
    logic [TW-1:0]   r_phase, n_phase;
    logic [DW-1:0]   r_cell, n_cell;
    logic            r_adv, n_adv;
    logic [tcw_pkg::C_IDX_W-1:0] r_idx, n_idx;
    logic [DW-1:0]   r_data, n_data;
    logic            r_scrolled, n_scrolled;
    logic            r_wp, n_wp;
    logic [AW-1:0]   r_wp_addr, n_wp_addr;
    logic            r_wp_zero, n_wp_zero;
    logic            r_o_valid, n_o_valid;
    logic [DW-1:0]   r_o_data, n_o_data;
    logic [CW-1:0]   r_o_col, n_o_col;
    logic [RW-1:0]   r_o_row, n_o_row;
    logic            r_o_scroll, n_o_scroll;

    tcw_pkg::t_alu_req      w_alu_req;
    logic [tcw_pkg::C_SUM_W-1:0] w_sum;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [DW-1:0]          w_wdata;
    logic [AW-1:0]          w_raddr;
    logic [DW-1:0]          w_rdata;
    logic                   w_accept;
    logic [CW:0]            w_tab_col;
    logic                   w_idx_ok;
    logic                   w_last_col;
    logic                   w_last_row;
    logic                   w_last_cnt;
    logic [TW-1:0]          w_phase_inc;
    logic [TW-1:0]          w_phase_dec;

    // Shared address adder
    tcw_alu u_alu (
        .i_req (w_alu_req),
        .o_sum (w_sum)
    );

    // Cell store
    tcw_ram #(
        .WIDTH (DW),
        .DEPTH (tcw_pkg::C_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == tcw_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode helpers
    assign w_tab_col  = {1'b0, r_col} + (CW + 1)'(tcw_pkg::C_TAB_STOP)
                        - (CW + 1)'(r_phase);
    assign w_idx_ok   = ({1'b0, i_cell_index} < (tcw_pkg::C_IDX_W + 1)'(tcw_pkg::C_CELLS));
    assign w_last_col = (r_col == CW'(tcw_pkg::C_COLS - 1));
    assign w_last_row = (r_row == RW'(tcw_pkg::C_ROWS - 1));
    assign w_last_cnt = (r_cnt == AW'(tcw_pkg::C_CELLS - 1));
    assign w_phase_inc = (r_phase == TW'(tcw_pkg::C_TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
    assign w_phase_dec = (r_phase == '0) ? TW'(tcw_pkg::C_TAB_STOP - 1) : r_phase - 1'b1;

    // Address unit request per state
    always_comb begin
        w_alu_req.row_base = r_row_base;
        w_alu_req.col      = r_col;
        w_alu_req.cnt      = r_cnt;
        case (r_state)
            tcw_pkg::S_NEXT:   w_alu_req.op = tcw_pkg::ALU_ROW_DOWN;
            tcw_pkg::S_SCROLL: w_alu_req.op = tcw_pkg::ALU_SRC;
            default:           w_alu_req.op = tcw_pkg::ALU_CELL;
        endcase
    end

    // Store port muxing: pending scroll write, cell write, clear sweep
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        if (r_wp) begin
            w_we    = 1'b1;
            w_waddr = r_wp_addr;
            w_wdata = r_wp_zero ? '0 : w_rdata;
        end else if (r_state == tcw_pkg::S_WRITE) begin
            w_we    = 1'b1;
            w_waddr = w_sum[AW-1:0];
            w_wdata = r_cell;
        end else if (r_state == tcw_pkg::S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_cnt;
            w_wdata = '0;
        end
        w_raddr = (r_state == tcw_pkg::S_SCROLL) ? w_sum[AW-1:0] : AW'(r_idx);
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_boot     = r_boot;
        n_cnt      = r_cnt;
        n_col      = r_col;
        n_row      = r_row;
        n_row_base = r_row_base;
        n_phase    = r_phase;
        n_cell     = r_cell;
        n_adv      = r_adv;
        n_idx      = r_idx;
        n_data     = r_data;
        n_scrolled = r_scrolled;
        n_wp       = 1'b0;
        n_wp_addr  = r_wp_addr;
        n_wp_zero  = r_wp_zero;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_data   = r_o_data;
        n_o_col    = r_o_col;
        n_o_row    = r_o_row;
        n_o_scroll = r_o_scroll;

        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_data     = '0;
                    n_scrolled = 1'b0;
                    n_idx      = i_cell_index;
                    n_cnt      = '0;
                    n_state    = tcw_pkg::S_DONE;
                    if (i_cmd == tcw_pkg::CMD_PUT) begin
                        if (i_char_code == tcw_pkg::CH_NEWLINE) begin
                            n_state = tcw_pkg::S_NEXT;
                        end else if (i_char_code == tcw_pkg::CH_BACKSPACE) begin
                            if (r_col != '0) begin
                                n_col   = r_col - 1'b1;
                                n_phase = w_phase_dec;
                                n_cell  = {i_bg_color, i_fg_color, tcw_pkg::CH_SPACE};
                                n_adv   = 1'b0;
                                n_state = tcw_pkg::S_WRITE;
                            end
                        end else if (i_char_code == tcw_pkg::CH_TAB) begin
                            if (w_tab_col >= (CW + 1)'(tcw_pkg::C_COLS)) begin
                                n_state = tcw_pkg::S_NEXT;
                            end else begin
                                n_col   = w_tab_col[CW-1:0];
                                n_phase = '0;
                            end
                        end else if (i_char_code == tcw_pkg::CH_RETURN) begin
                            n_col   = '0;
                            n_phase = '0;
                        end else begin
                            n_cell  = {i_bg_color, i_fg_color, i_char_code};
                            n_adv   = 1'b1;
                            n_state = tcw_pkg::S_WRITE;
                        end
                    end else if (i_cmd == tcw_pkg::CMD_READ) begin
                        if (w_idx_ok) begin
                            n_state = tcw_pkg::S_READ;
                        end
                    end else if (i_cmd == tcw_pkg::CMD_CLEAR) begin
                        n_state = tcw_pkg::S_CLEAR;
                    end
                end
            end
            tcw_pkg::S_WRITE: begin
                // Cell written this cycle; advance the cursor for printables
                n_state = tcw_pkg::S_DONE;
                if (r_adv) begin
                    if (w_last_col) begin
                        n_state = tcw_pkg::S_NEXT;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_phase = w_phase_inc;
                    end
                end
            end
            tcw_pkg::S_NEXT: begin
                n_col   = '0;
                n_phase = '0;
                if (w_last_row) begin
                    n_scrolled = 1'b1;
                    n_cnt      = '0;
                    n_state    = tcw_pkg::S_SCROLL;
                end else begin
                    n_row      = r_row + 1'b1;
                    n_row_base = w_sum[AW-1:0];
                    n_state    = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_SCROLL: begin
                // Read one row down now, write it back in the next cycle
                n_wp      = 1'b1;
                n_wp_addr = r_cnt;
                n_wp_zero = (r_cnt >= AW'(tcw_pkg::C_CELLS - tcw_pkg::C_COLS));
                n_cnt     = r_cnt + 1'b1;
                if (w_last_cnt) begin
                    n_state = tcw_pkg::S_FLUSH;
                end
            end
            tcw_pkg::S_FLUSH: begin
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (w_last_cnt) begin
                    n_col      = '0;
                    n_row      = '0;
                    n_row_base = '0;
                    n_phase    = '0;
                    n_boot     = 1'b0;
                    n_state    = r_boot ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_READ: begin
                n_state = tcw_pkg::S_RDATA;
            end
            tcw_pkg::S_RDATA: begin
                n_data  = w_rdata;
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = r_data;
                    n_o_col    = r_col;
                    n_o_row    = r_row;
                    n_o_scroll = r_scrolled;
                    n_state    = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcw_pkg::S_CLEAR;
            r_boot     <= 1'b1;
            r_cnt      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
            r_phase    <= '0;
            r_wp       <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_boot     <= n_boot;
            r_cnt      <= n_cnt;
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
            r_phase    <= n_phase;
            r_wp       <= n_wp;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cell     <= n_cell;
        r_adv      <= n_adv;
        r_idx      <= n_idx;
        r_data     <= n_data;
        r_scrolled <= n_scrolled;
        r_wp_addr  <= n_wp_addr;
        r_wp_zero  <= n_wp_zero;
        r_o_data   <= n_o_data;
        r_o_col    <= n_o_col;
        r_o_row    <= n_o_row;
        r_o_scroll <= n_o_scroll;
    end

    assign o_out_valid  = r_o_valid;
    assign o_read_data  = r_o_data;
    assign o_cursor_col = r_o_col;
    assign o_cursor_row = r_o_row;
    assign o_did_scroll = r_o_scroll;

endmodule

>>> hdl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [tcw_pkg::C_CELL_W-1:0]   o_read_data,
    input logic [tcw_pkg::C_COL_W-1:0]    o_cursor_col,
    input logic [tcw_pkg::C_ROW_W-1:0]    o_cursor_row,
    input logic                           o_did_scroll
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_cursor_col) && $stable(o_cursor_row) && $stable(o_did_scroll))
        else $error("result word changed while stalled");

    // Cursor column stays on screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_col < tcw_pkg::C_COL_W'(tcw_pkg::C_COLS))
        else $error("cursor column off screen");

    // Cursor row stays on screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_row < tcw_pkg::C_ROW_W'(tcw_pkg::C_ROWS))
        else $error("cursor row off screen");

    // A scroll leaves the cursor at the start of the last row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_scroll |->
            o_cursor_row == tcw_pkg::C_ROW_W'(tcw_pkg::C_ROWS - 1) && o_cursor_col == '0)
        else $error("scroll left cursor off the last row start");

    // One word at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after an accept");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_data  (o_read_data),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row),
    .o_did_scroll (o_did_scroll)
);
